[rtl/core/tssg_pkg.sv]
// Shared types and default constants for the triangle span generator.
package tssg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Request codes on the input channel.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SPAN = 1'b1;

  // Which half of the triangle is being walked.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BOTTOM = 2'd1,
    PH_TOP    = 2'd2
  } phase_t;

  // Setup sequencer states.
  typedef enum logic [2:0] {
    ST_READY,
    ST_PROD,
    ST_SUM,
    ST_SPLIT,
    ST_SLOPE_L,
    ST_SLOPE_R
  } st_t;

  // Start and finish of one divide between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

[rtl/core/triangle_scanline_span_generator.sv]
// Top level of the triangle scanline span generator.
// A taken span request writes its span into the output register in the next cycle.
// A load runs two serial divides for a flat-top or flat-bottom triangle, and a product
// step, a sum step and three divides otherwise; NUM_W, the divider width, is max(2*COORD_BITS+3,
// COORD_BITS+1+FRAC_BITS), 29 at the defaults. The step from the lower to the upper half
// runs two more divides after that span, all on the shared bit-serial divider.
// Reset (synchronous, rst_n low) empties the output register and leaves no triangle active.
module triangle_scanline_span_generator import tssg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic signed [COORD_BITS-1:0] in_first_x,
  input  logic signed [COORD_BITS-1:0] in_first_y,
  input  logic signed [COORD_BITS-1:0] in_second_x,
  input  logic signed [COORD_BITS-1:0] in_second_y,
  input  logic signed [COORD_BITS-1:0] in_third_x,
  input  logic signed [COORD_BITS-1:0] in_third_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_span_y,
  output logic signed [COORD_BITS-1:0] out_span_start_x,
  output logic signed [COORD_BITS-1:0] out_span_end_x,
  output logic                         out_last_span
);

  localparam int CW1   = COORD_BITS + 1;
  localparam int PRD_W = 2 * COORD_BITS + 2;
  localparam int SUM_W = PRD_W + 1;
  localparam int SLP_W = COORD_BITS + 1 + FRAC_BITS;
  localparam int NUM_W = (SUM_W > SLP_W) ? SUM_W : SLP_W;
  localparam int ACC_W = COORD_BITS + FRAC_BITS + 3;

  // ------------------------------------------------------------------
  // Handshake. A load never makes a span, so it is taken even while a
  // span waits in the output register; a span request waits for room.
  // ------------------------------------------------------------------
  st_t    state_r, state_nxt;
  phase_t phase_r;
  logic   out_valid_r;
  logic   in_accept;
  logic   span_fire;
  logic   load_fire;

  assign in_stall  = (state_r != ST_READY) ||
                     (out_valid_r && out_stall && (in_req_type == REQ_SPAN));
  assign in_accept = in_valid && !in_stall;
  assign load_fire = in_accept && (in_req_type == REQ_LOAD);
  assign span_fire = in_accept && (in_req_type == REQ_SPAN) && (phase_r != PH_IDLE);

  // ------------------------------------------------------------------
  // Sort the incoming vertices by y with three compare-and-swap passes
  // that only swap on strictly less, so equal rows keep their order.
  // ------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] sx [3];
  logic signed [COORD_BITS-1:0] sy [3];
  logic signed [COORD_BITS-1:0] tx;
  logic signed [COORD_BITS-1:0] ty;
  logic                         s_flat_top;
  logic                         s_flat_bot;

  always_comb begin
    sx[0] = in_first_x;  sy[0] = in_first_y;
    sx[1] = in_second_x; sy[1] = in_second_y;
    sx[2] = in_third_x;  sy[2] = in_third_y;
    tx = '0;
    ty = '0;
    if (sy[1] < sy[0]) begin
      tx = sx[1]; ty = sy[1]; sx[1] = sx[0]; sy[1] = sy[0]; sx[0] = tx; sy[0] = ty;
    end
    if (sy[2] < sy[0]) begin
      tx = sx[2]; ty = sy[2]; sx[2] = sx[0]; sy[2] = sy[0]; sx[0] = tx; sy[0] = ty;
    end
    if (sy[2] < sy[1]) begin
      tx = sx[2]; ty = sy[2]; sx[2] = sx[1]; sy[2] = sy[1]; sx[1] = tx; sy[1] = ty;
    end
  end

  assign s_flat_top = (sy[1] != sy[2]) && (sy[0] == sy[1]);
  assign s_flat_bot = (sy[1] == sy[2]);

  // ------------------------------------------------------------------
  // Triangle state.
  // ------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] xl_r, yl_r, xm_r, ym_r, xh_r, yh_r;
  logic signed [COORD_BITS-1:0] split_x_r;
  logic signed [COORD_BITS-1:0] row_r;
  logic signed [ACC_W-1:0]      edge_l_r, edge_r_r;
  logic signed [SLP_W-1:0]      slope_l_r, slope_r_r;
  logic signed [PRD_W-1:0]      prod_r;
  logic signed [SUM_W-1:0]      num_r;
  logic                         div_run_r;

  // Row and x differences, one bit wider than a coordinate.
  logic signed [CW1-1:0] dy_lh, dy_lm, dy_mh, dx_lh;
  logic signed [PRD_W-1:0] prod_a, prod_b;

  assign dy_lh = CW1'(yh_r) - CW1'(yl_r);
  assign dy_lm = CW1'(ym_r) - CW1'(yl_r);
  assign dy_mh = CW1'(yh_r) - CW1'(ym_r);
  assign dx_lh = CW1'(xh_r) - CW1'(xl_r);
  assign prod_a = PRD_W'(xl_r) * PRD_W'(dy_lh);
  assign prod_b = PRD_W'(dy_lm) * PRD_W'(dx_lh);

  // The upper half starts from the top vertex. A flat-top triangle aims its edges at the
  // two low vertices; otherwise they aim at the middle vertex and the split point.
  logic                         flat_top_now;
  logic signed [COORD_BITS-1:0] top_a, top_b;

  assign flat_top_now = (yl_r == ym_r);
  assign top_a        = flat_top_now ? xl_r : xm_r;
  assign top_b        = flat_top_now ? xm_r : split_x_r;

  // ------------------------------------------------------------------
  // Divider operands. The split point divides the exact interpolation
  // product by the full height; each slope divides dx * 2^FRAC_BITS by
  // the height of its half.
  // ------------------------------------------------------------------
  div_ctl_t                div_ctl;
  div_sts_t                div_sts;
  logic signed [NUM_W-1:0] div_num;
  logic [COORD_BITS-1:0]   div_den;
  logic signed [NUM_W:0]   div_quot;
  logic signed [CW1-1:0]   dx_sel;
  logic signed [CW1-1:0]   dy_sel;

  always_comb begin
    dx_sel = '0;
    dy_sel = '0;
    case (state_r)
      ST_SLOPE_L: begin
        if (phase_r == PH_TOP) begin
          dx_sel = CW1'(xh_r) - CW1'(top_a);
          dy_sel = dy_mh;
        end else begin
          dx_sel = CW1'(xm_r) - CW1'(xl_r);
          dy_sel = dy_lm;
        end
      end
      ST_SLOPE_R: begin
        if (phase_r == PH_TOP) begin
          dx_sel = CW1'(xh_r) - CW1'(top_b);
          dy_sel = dy_mh;
        end else begin
          dx_sel = CW1'(split_x_r) - CW1'(xl_r);
          dy_sel = dy_lm;
        end
      end
      default: begin
        dx_sel = '0;
        dy_sel = dy_lh;
      end
    endcase
  end

  assign div_num = (state_r == ST_SPLIT) ? NUM_W'(num_r) : (NUM_W'(dx_sel) <<< FRAC_BITS);
  assign div_den = dy_sel[COORD_BITS-1:0];

  tssg_div #(
    .NUM_W (NUM_W),
    .DEN_W (COORD_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quot  (div_quot)
  );

  // ------------------------------------------------------------------
  // Span arithmetic: x is the accumulator shifted down, rounded toward
  // zero, so a negative value with fraction bits left moves up by one.
  // ------------------------------------------------------------------
  logic signed [ACC_W-1:0] sh_l, sh_r;
  logic signed [ACC_W-1:0] span_xl, span_xr;
  logic signed [CW1-1:0]   row_m1;
  logic                    bot_end;
  logic                    top_end;

  assign sh_l    = edge_l_r >>> FRAC_BITS;
  assign sh_r    = edge_r_r >>> FRAC_BITS;
  assign span_xl = sh_l + ACC_W'(edge_l_r[ACC_W-1] && (|edge_l_r[FRAC_BITS-1:0]));
  assign span_xr = sh_r + ACC_W'(edge_r_r[ACC_W-1] && (|edge_r_r[FRAC_BITS-1:0]));
  assign row_m1  = CW1'(row_r) - CW1'(1);
  assign bot_end = (row_r >= ym_r);
  assign top_end = (row_m1 <= CW1'(ym_r));

  // ------------------------------------------------------------------
  // Setup sequencer: next state.
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_READY: begin
        if (load_fire) begin
          state_nxt = (s_flat_top || s_flat_bot) ? ST_SLOPE_L : ST_PROD;
        end else if (span_fire && (phase_r == PH_BOTTOM) && bot_end && (ym_r != yh_r)) begin
          state_nxt = ST_SLOPE_L;
        end
      end
      ST_PROD:    state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_SPLIT;
      ST_SPLIT:   if (div_sts.done) state_nxt = ST_SLOPE_L;
      ST_SLOPE_L: if (div_sts.done) state_nxt = ST_SLOPE_R;
      ST_SLOPE_R: if (div_sts.done) state_nxt = ST_READY;
      default:    state_nxt = ST_READY;
    endcase
  end

  // Setup sequencer: outputs. A divide is launched once on entry to each divide state.
  always_comb begin
    div_ctl.start = 1'b0;
    case (state_r)
      ST_SPLIT, ST_SLOPE_L, ST_SLOPE_R: div_ctl.start = !div_run_r;
      default:                          div_ctl.start = 1'b0;
    endcase
  end

  // ------------------------------------------------------------------
  // Control registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      div_run_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_ctl.start) begin
        div_run_r <= 1'b1;
      end else if (div_sts.done) begin
        div_run_r <= 1'b0;
      end
      if (span_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load_fire) begin
        phase_r <= s_flat_top ? PH_TOP : PH_BOTTOM;
      end else if (span_fire) begin
        if (phase_r == PH_BOTTOM) begin
          if (bot_end) begin
            phase_r <= (ym_r == yh_r) ? PH_IDLE : PH_TOP;
          end
        end else if (top_end) begin
          phase_r <= PH_IDLE;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Datapath registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load_fire) begin
      xl_r <= sx[0]; yl_r <= sy[0];
      xm_r <= sx[1]; ym_r <= sy[1];
      xh_r <= sx[2]; yh_r <= sy[2];
      if (s_flat_top) begin
        split_x_r <= '0;
        edge_l_r  <= ACC_W'(sx[2]) <<< FRAC_BITS;
        edge_r_r  <= ACC_W'(sx[2]) <<< FRAC_BITS;
        row_r     <= sy[2];
      end else begin
        if (s_flat_bot) begin
          split_x_r <= sx[2];
        end
        edge_l_r <= ACC_W'(sx[0]) <<< FRAC_BITS;
        edge_r_r <= ACC_W'(sx[0]) <<< FRAC_BITS;
        row_r    <= sy[0];
      end
    end else if (span_fire) begin
      if (phase_r == PH_BOTTOM) begin
        if (bot_end && (ym_r != yh_r)) begin
          // Hand over to the upper half, which walks down from the top vertex.
          edge_l_r <= ACC_W'(xh_r) <<< FRAC_BITS;
          edge_r_r <= ACC_W'(xh_r) <<< FRAC_BITS;
          row_r    <= yh_r;
        end else begin
          edge_l_r <= edge_l_r + ACC_W'(slope_l_r);
          edge_r_r <= edge_r_r + ACC_W'(slope_r_r);
          row_r    <= row_r + COORD_BITS'(1);
        end
      end else begin
        edge_l_r <= edge_l_r - ACC_W'(slope_l_r);
        edge_r_r <= edge_r_r - ACC_W'(slope_r_r);
        row_r    <= row_m1[COORD_BITS-1:0];
      end
    end
    if (state_r == ST_PROD) begin
      prod_r <= prod_a;
    end
    if (state_r == ST_SUM) begin
      num_r <= SUM_W'(prod_r) + SUM_W'(prod_b);
    end
    if (div_sts.done) begin
      case (state_r)
        ST_SPLIT:   split_x_r <= div_quot[COORD_BITS-1:0];
        ST_SLOPE_L: slope_l_r <= div_quot[SLP_W-1:0];
        ST_SLOPE_R: slope_r_r <= div_quot[SLP_W-1:0];
        default:    ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (span_fire) begin
      out_span_y       <= row_r;
      out_span_start_x <= span_xl[COORD_BITS-1:0];
      out_span_end_x   <= span_xr[COORD_BITS-1:0];
      out_last_span    <= (phase_r == PH_BOTTOM) ? (bot_end && (ym_r == yh_r)) : top_end;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/tssg_div.sv]
// Bit-serial restoring divider: signed numerator by non-negative denominator.
module tssg_div import tssg_pkg::*; #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  div_ctl_t                ctl,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output div_sts_t                sts,
  output logic signed [NUM_W:0]   quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic             zero_r;

  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;
  logic [NUM_W-1:0] mag;

  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_W'(1));
      if (ctl.start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // One quotient bit per cycle, shifted in from the bottom as the numerator leaves the top.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r  <= '0;
      q_r    <= mag;
      den_r  <= den;
      neg_r  <= num[NUM_W-1];
      zero_r <= (den == '0);
    end else if (run_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], fits};
    end
  end

  assign sts.done = done_r;

  always_comb begin
    if (zero_r) begin
      quot = '0;
    end else if (neg_r) begin
      quot = -$signed({1'b0, q_r});
    end else begin
      quot = $signed({1'b0, q_r});
    end
  end

endmodule

[rtl/core/tssg_checker.sv]
// Port-level checks for the triangle span generator, bound to the top level.
module tssg_checker import tssg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  in_req_type,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_span_y,
  input logic [COORD_BITS-1:0] out_span_start_x,
  input logic [COORD_BITS-1:0] out_span_end_x,
  input logic                  out_last_span
);

  // A held span keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_span_y) &&
      $stable(out_span_start_x) && $stable(out_span_end_x) && $stable(out_last_span))
    else $error("held span changed");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A load transfer never produces a span.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_LOAD) && !(out_valid && out_stall)
      |=> !out_valid)
    else $error("span after a load");

  // A span request is not taken while a span is held.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && (in_req_type == REQ_SPAN) && out_valid && out_stall |-> in_stall)
    else $error("span request taken over a held span");

endmodule

bind triangle_scanline_span_generator tssg_checker #(
  .COORD_BITS (COORD_BITS)
) u_tssg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_req_type      (in_req_type),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_span_y       (out_span_y),
  .out_span_start_x (out_span_start_x),
  .out_span_end_x   (out_span_end_x),
  .out_last_span    (out_last_span)
);

[sim/tb_triangle_scanline_span_generator.sv]
// Self-checking testbench for the triangle scanline span generator.
`timescale 1ns / 1ps

module tb_triangle_scanline_span_generator;
  import tssg_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int FB        = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 5000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t row;
    coord_t x0;
    coord_t x1;
    logic   last;
  } span_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  logic   in_req_type;
  coord_t in_first_x, in_first_y, in_second_x, in_second_y, in_third_x, in_third_y;
  logic   out_valid;
  logic   out_stall;
  coord_t out_span_y, out_span_start_x, out_span_end_x;
  logic   out_last_span;

  triangle_scanline_span_generator dut (.*);

  // Shadow copy of the span walker: sorted vertices, long-edge split point,
  // current half and the fixed-point edge accumulators.
  int     vtx[6];
  int     split_pt;
  phase_t walk_ph;
  longint acc_l, acc_r, step_l, step_r;
  int     row_next;

  span_t  span_q[$];

  int     mismatches;
  int     n_items, n_spans, n_tris;
  int     hold_cycles;   // receiver hold-off requested by a test
  bit     calm;          // no random idling on either side

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint slope_of(int dx, int dy);
    if (dy == 0) return 0;
    return (longint'(dx) * (longint'(1) <<< FB)) / longint'(dy);
  endfunction

  function automatic void swap_vtx(int a, int b);
    int tx, ty;
    tx = vtx[2*a];
    ty = vtx[2*a+1];
    vtx[2*a]   = vtx[2*b];
    vtx[2*a+1] = vtx[2*b+1];
    vtx[2*b]   = tx;
    vtx[2*b+1] = ty;
  endfunction

  // Set up the upper half: both edges start at the top vertex and walk down.
  function automatic void begin_upper(int xa, int xb);
    step_l   = slope_of(vtx[4] - xa, vtx[5] - vtx[3]);
    step_r   = slope_of(vtx[4] - xb, vtx[5] - vtx[3]);
    acc_l    = longint'(vtx[4]) <<< FB;
    acc_r    = acc_l;
    row_next = vtx[5];
    walk_ph  = PH_TOP;
  endfunction

  function automatic void load_triangle(coord_t c[6]);
    longint num;
    for (int i = 0; i < 6; i++) vtx[i] = int'(c[i]);
    // Stable sort by y; swaps only on strictly smaller y.
    if (vtx[3] < vtx[1]) swap_vtx(1, 0);
    if (vtx[5] < vtx[1]) swap_vtx(2, 0);
    if (vtx[5] < vtx[3]) swap_vtx(2, 1);
    if (vtx[3] != vtx[5] && vtx[1] == vtx[3]) begin
      // Flat top: only the upper half is walked.
      split_pt = 0;
      begin_upper(vtx[0], vtx[2]);
      return;
    end
    if (vtx[3] == vtx[5]) begin
      split_pt = vtx[4];
    end else begin
      num = longint'(vtx[0]) * longint'(vtx[5] - vtx[1])
          + longint'(vtx[3] - vtx[1]) * longint'(vtx[4] - vtx[0]);
      split_pt = int'(num / longint'(vtx[5] - vtx[1]));
    end
    step_l   = slope_of(vtx[2] - vtx[0], vtx[3] - vtx[1]);
    step_r   = slope_of(split_pt - vtx[0], vtx[3] - vtx[1]);
    acc_l    = longint'(vtx[0]) <<< FB;
    acc_r    = acc_l;
    row_next = vtx[1];
    walk_ph  = PH_BOTTOM;
  endfunction

  // Emit the next span of the active triangle into the expectation queue.
  function automatic void next_span();
    span_t  s;
    int     r;
    longint one;
    one = longint'(1) <<< FB;
    if (walk_ph == PH_IDLE) return;
    r      = row_next;
    s.row  = r[CB-1:0];
    s.x0   = coord_t'(acc_l / one);
    s.x1   = coord_t'(acc_r / one);
    s.last = 1'b0;
    if (walk_ph == PH_BOTTOM) begin
      acc_l += step_l;
      acc_r += step_r;
      row_next = r + 1;
      if (r >= vtx[3]) begin
        if (vtx[3] == vtx[5]) begin
          s.last  = 1'b1;
          walk_ph = PH_IDLE;
        end else begin
          begin_upper(vtx[2], split_pt);
        end
      end
    end else begin
      acc_l -= step_l;
      acc_r -= step_r;
      row_next = r - 1;
      if (r - 1 <= vtx[3]) begin
        s.last  = 1'b1;
        walk_ph = PH_IDLE;
      end
    end
    span_q.push_back(s);
  endfunction

  // Offer one request and hold it until the block takes it. Acceptance is
  // judged from in_stall at the falling edge, where it is settled.
  task automatic send_req(logic req, coord_t c[6]);
    bit taken;
    int gap, r;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_first_x  <= c[0];
    in_first_y  <= c[1];
    in_second_x <= c[2];
    in_second_y <= c[3];
    in_third_x  <= c[4];
    in_third_y  <= c[5];
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    n_items++;
    if (req == REQ_LOAD) begin
      load_triangle(c);
      n_tris++;
    end else begin
      next_span();
    end
    r   = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 70 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic span_req();
    coord_t c[6];
    foreach (c[i]) c[i] = coord_t'($urandom);
    send_req(REQ_SPAN, c);
  endtask

  // Load a triangle and request spans until it is done (or n requests).
  task automatic run_tri(coord_t c[6], int n = -1);
    send_req(REQ_LOAD, c);
    if (n < 0) begin
      while (walk_ph != PH_IDLE) span_req();
    end else begin
      repeat (n) span_req();
    end
  endtask

  task automatic wait_drain();
    while (span_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    span_req();                                            // nothing active yet
    run_tri('{10, 5, 4, 9, 20, 9});                        // flat bottom
    run_tri('{3, 2, 15, 2, 8, 8});                         // flat top
    run_tri('{0, 0, 12, 4, -6, 10});                       // general split
    run_tri('{-7, 30, 40, 30, 100, 30});                   // single row
    run_tri('{5, 5, 5, 5, 5, 5});                          // one point
    run_tri('{-2048, 2043, 2047, 2047, 0, 2045});          // extreme corners
    run_tri('{2047, -2048, -2048, -2045, -2048, -2046});
    run_tri('{1, 1, 50, 6, -20, 11}, 3);                   // abandoned midway
    run_tri('{-1, -3, 9, -1, 4, -5});
    span_req();                                            // after last span
    wait_drain();
  endtask

  // Mostly complete triangles with random vertices; short rows for most of
  // them, a few tall ones, plus abandoned loads and stray span requests.
  task automatic test_random(int n_target);
    coord_t c[6];
    int ext, base, r;
    while (n_items < n_target) begin
      r   = $urandom_range(0, 99);
      ext = (r < 85) ? $urandom_range(0, 12) : (r < 97 ? $urandom_range(13, 80)
                                                       : $urandom_range(200, 600));
      base = $urandom_range(0, 4095 - ext) - 2048;
      for (int i = 0; i < 3; i++) begin
        c[2*i]   = coord_t'($urandom);
        c[2*i+1] = coord_t'(base + $urandom_range(0, ext));
      end
      r = $urandom_range(0, 99);
      if (r < 80) run_tri(c);
      else if (r < 92) run_tri(c, $urandom_range(0, 4));
      else begin
        for (int i = 0; i < 6; i++) c[i] = coord_t'($urandom);
        run_tri(c, 1);
        repeat ($urandom_range(1, 3)) span_req();
      end
      if ($urandom_range(0, 19) == 0) wait_drain();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // span requests, so the block backs up and stalls its input.
  task automatic test_backpressure();
    wait_drain();
    calm = 1'b1;
    hold_cycles = 300;
    run_tri('{0, 0, 30, 20, -30, 40});
    wait_drain();
    calm = 1'b0;
  endtask

  // Receiver side: random stall pattern, long forced holds on request.
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 149) == 0) burst = $urandom_range(10, 50);
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  // Result checker: each transfer is compared with the oldest expected span.
  always @(negedge clk) begin
    span_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (span_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected span: y=%0d x0=%0d x1=%0d last=%0b",
                   out_span_y, out_span_start_x, out_span_end_x, out_last_span);
      end else begin
        e = span_q.pop_front();
        n_spans++;
        if (out_span_y !== e.row || out_span_start_x !== e.x0 ||
            out_span_end_x !== e.x1 || out_last_span !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"span mismatch: exp y=%0d x0=%0d x1=%0d last=%0b, ",
                      "got y=%0d x0=%0d x1=%0d last=%0b"},
                     e.row, e.x0, e.x1, e.last,
                     out_span_y, out_span_start_x, out_span_end_x, out_last_span);
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    forever begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d spans outstanding", span_q.size());
        $display("tb_triangle_scanline_span_generator: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    {in_first_x, in_first_y, in_second_x, in_second_y, in_third_x, in_third_y} = '0;
    mismatches = 0;
    n_items = 0;
    n_spans = 0;
    n_tris = 0;
    hold_cycles = 0;
    calm = 1'b0;
    walk_ph = PH_IDLE;
    foreach (vtx[i]) vtx[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(1200);
    in_valid <= 1'b0;
    wait_drain();
    repeat (200) @(posedge clk);

    $display("Covered %0d requests over %0d triangles, %0d spans checked,",
             n_items, n_tris, n_spans);
    $display("with random idling, a long receiver hold-off and drained pauses.");
    if (mismatches == 0 && span_q.size() == 0) begin
      $display("tb_triangle_scanline_span_generator: PASS");
    end else begin
      $display("%0d mismatches, %0d spans never seen", mismatches, span_q.size());
      $display("tb_triangle_scanline_span_generator: FAIL");
    end
    $finish;
  end

endmodule
